// ===== sv/bcc_pkg.sv =====
// Shared types and constants for the button click classifier.
// Holds the item structs, phase enum, event/command codes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  // Tick counter width and saturation value
  localparam int unsigned TickW = 16;
  localparam logic [TickW-1:0] TICK_MAX = {TickW{1'b1}};

  // Quiet time before a press is taken, in ticks
  localparam logic [TickW-1:0] IDLE_TICKS_DEFAULT = 16'd50;

  // Configuration register reset values
  localparam logic [TickW-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [TickW-1:0] LONG_RESET     = 16'd800;
  localparam logic [TickW-1:0] DOUBLE_RESET   = 16'd300;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_LONG     = 2'd1;
  localparam logic [1:0] CFG_DOUBLE   = 2'd2;

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_TEST = 2'd2;

  // Event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_CLICK  = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  // Classifier phases
  typedef enum logic [2:0] {
    PH_WAIT,
    PH_DEBOUNCE,
    PH_CHECK,
    PH_DCHECK,
    PH_DHELD,
    PH_LHELD
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic       button_level;
    logic [1:0] query_event;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       event_match;
  } out_item_t;

  typedef struct packed {
    logic [TickW-1:0] debounce_ticks;
    logic [TickW-1:0] long_ticks;
    logic [TickW-1:0] double_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/bcc_step.sv =====
// Classifier state (phase, tick count, pending event) and its per-item update.
// Depends on bcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcc_step #(
  parameter logic [bcc_pkg::TickW-1:0] IDLE_TICKS = bcc_pkg::IDLE_TICKS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire bcc_pkg::in_item_t  item,
  input  wire bcc_pkg::cfg_t      cfg,
  output bcc_pkg::out_item_t      result
);
  import bcc_pkg::*;

  phase_t           phase, phase_next;
  logic [TickW-1:0] ticks, ticks_next;
  logic [1:0]       pending, pending_next;
  logic [1:0]       event_tick;
  logic             pressed;
  logic             done_idle, done_deb, done_long, done_dbl;

  assign pressed   = item.button_level;
  assign done_idle = (ticks >= IDLE_TICKS);
  assign done_deb  = (ticks >= cfg.debounce_ticks);
  assign done_long = (ticks >= cfg.long_ticks);
  assign done_dbl  = (ticks >= cfg.double_ticks);

  // Next phase and event raised by a tick
  always_comb begin
    phase_next = phase;
    event_tick = pending;
    unique case (phase)
      PH_DEBOUNCE: begin
        // timeout wins over release
        if (done_deb) begin
          phase_next = PH_CHECK;
        end else if (!pressed) begin
          phase_next = PH_WAIT;
        end
      end
      PH_CHECK: begin
        if (done_long) begin
          phase_next = PH_LHELD;
          event_tick = EV_LONG;
        end else if (!pressed) begin
          phase_next = PH_DCHECK;
        end
      end
      PH_DCHECK: begin
        if (done_dbl) begin
          phase_next = PH_WAIT;
          event_tick = EV_CLICK;
        end else if (pressed) begin
          phase_next = PH_DHELD;
          event_tick = EV_DOUBLE;
        end
      end
      PH_DHELD, PH_LHELD: begin
        if (!pressed) phase_next = PH_WAIT;
      end
      default: begin
        // wait, and unused encodings fall back to it
        phase_next = (done_idle && pressed) ? PH_DEBOUNCE : PH_WAIT;
      end
    endcase
  end

  // Tick count: cleared on phase change, else saturating increment
  always_comb begin
    if (phase_next != phase) begin
      ticks_next = '0;
    end else if (ticks != TICK_MAX) begin
      ticks_next = ticks + 1'b1;
    end else begin
      ticks_next = ticks;
    end
  end

  // Result and pending event per command
  always_comb begin
    result.event_code  = pending;
    result.event_match = 1'b0;
    pending_next       = pending;
    unique case (item.command)
      CMD_TICK: begin
        result.event_code = event_tick;
        pending_next      = event_tick;
      end
      CMD_READ: begin
        pending_next = EV_NONE;
      end
      CMD_TEST: begin
        if (item.query_event == pending) begin
          result.event_match = 1'b1;
          pending_next       = EV_NONE;
        end
      end
      default: begin
        // unused command: report only
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_WAIT;
      ticks   <= '0;
      pending <= EV_NONE;
    end else if (advance) begin
      if (item.command == CMD_TICK) begin
        phase <= phase_next;
        ticks <= ticks_next;
      end
      pending <= pending_next;
    end
  end

  // A match only reports the queried code
  a_match_code: assert property (@(posedge clk) disable iff (rst)
    advance && result.event_match |-> result.event_code == item.query_event)
    else $error("match reported for a different event code");

  // Non-tick commands leave the phase and tick count alone
  a_read_no_phase: assert property (@(posedge clk) disable iff (rst)
    advance && item.command != CMD_TICK |=> $stable(phase) && $stable(ticks))
    else $error("read command moved the phase");

  // Read clears the pending event
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.command == CMD_READ |=> pending == EV_NONE)
    else $error("read did not clear the pending event");

  // Phase change restarts the tick count
  a_phase_restart: assert property (@(posedge clk) disable iff (rst)
    advance && item.command == CMD_TICK && phase_next != phase |=> ticks == '0)
    else $error("tick count not cleared on phase change");

endmodule

`default_nettype wire

// ===== sv/button_click_classifier_core.sv =====
// Top level of the button click classifier: config registers, input and result registers.
// Depends on bcc_pkg and bcc_step.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  in      | in        | in_valid/in_stall  | in_item  (bcc_pkg::in_item_t)
//  out     | out       | out_valid/out_stall| out_item (bcc_pkg::out_item_t)
//  cfg     | in        | cfg_write          | cfg_index, cfg_data
//
// One item per cycle while out_stall is low; an item lands in the input register,
// is classified against the state and written to the result register, which
// sets out_valid.
// rst is synchronous: phase to wait, tick count and pending event to zero,
// config registers to 20/800/300, both pipeline registers empty.
// A stalled result holds the result register; the input register keeps
// accepting until it is full, then in_stall follows out_stall.
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier_core #(
  parameter logic [bcc_pkg::TickW-1:0] IDLE_TICKS = bcc_pkg::IDLE_TICKS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire bcc_pkg::in_item_t         in_item,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output bcc_pkg::out_item_t             out_item,
  input  wire logic                      cfg_write,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [bcc_pkg::TickW-1:0] cfg_data
);
  import bcc_pkg::*;

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_adv;
  logic      in_take;
  out_item_t step_result;

  // Handshake: stage 1 moves on when the result register is free or draining
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.long_ticks     <= LONG_RESET;
      cfg.double_ticks   <= DOUBLE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: cfg.debounce_ticks <= cfg_data;
        CFG_LONG:     cfg.long_ticks     <= cfg_data;
        CFG_DOUBLE:   cfg.double_ticks   <= cfg_data;
        default: begin
          // unused index: ignored
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item <= in_item;
  end

  bcc_step #(
    .IDLE_TICKS(IDLE_TICKS)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .advance(s1_adv),
    .item   (s1_item),
    .cfg    (cfg),
    .result (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_item <= step_result;
  end

  // Every item classified shows up as a result next cycle
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("classified item missing from result register");

  // Input side only stalls while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && s1_valid)
    else $error("input stalled without a blocked result");

  // A held item is not lost when the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |=> s1_valid)
    else $error("pending item dropped while output blocked");

endmodule

`default_nettype wire
